[sv/sdep_pkg.sv]
package sdep_pkg;

   localparam int BYTE_W   = 8;
   localparam int ID_W     = 16;
   localparam int COUNT_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int MORE_BIT = 7;

   localparam logic [BYTE_W-1:0] TYPE_COMMAND_RST  = 8'h10;
   localparam logic [BYTE_W-1:0] TYPE_RESPONSE_RST = 8'h20;
   localparam logic [BYTE_W-1:0] TYPE_ALERT_RST    = 8'h40;
   localparam logic [BYTE_W-1:0] TYPE_ERROR_RST    = 8'h80;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TYPE_COMMAND  = 2'd0,
      CSR_TYPE_RESPONSE = 2'd1,
      CSR_TYPE_ALERT    = 2'd2,
      CSR_TYPE_ERROR    = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_ID_LO   = 3'd1,
      PH_ID_HI   = 3'd2,
      PH_LEN     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef struct packed {
      logic               item_kind;
      logic [BYTE_W-1:0]  msg_type;
      logic [ID_W-1:0]    command_id;
      logic [COUNT_W-1:0] payload_count;
      logic               more_data;
      logic [BYTE_W-1:0]  data_byte;
      logic               last;
   } result_type;

endpackage

[sv/sdep_if.sv]
interface sdep_req_if import sdep_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sdep_rsp_if import sdep_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               item_kind;
   logic [BYTE_W-1:0]  msg_type;
   logic [ID_W-1:0]    command_id;
   logic [COUNT_W-1:0] payload_count;
   logic               more_data;
   logic [BYTE_W-1:0]  data_byte;
   logic               last;

   modport source (output valid, output item_kind, output msg_type, output command_id,
                   output payload_count, output more_data, output data_byte,
                   output last, input ready);
   modport sink (input valid, input item_kind, input msg_type, input command_id,
                 input payload_count, input more_data, input data_byte,
                 input last, output ready);
endinterface

interface sdep_csr_if import sdep_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[sv/sdep_type_regs.sv]
module sdep_type_regs import sdep_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   sdep_csr_if.sink          csr_ch,
   input  logic [BYTE_W-1:0] rx_byte,
   output logic              type_hit
);

   logic [BYTE_W-1:0] type_command_ff;
   logic [BYTE_W-1:0] type_response_ff;
   logic [BYTE_W-1:0] type_alert_ff;
   logic [BYTE_W-1:0] type_error_ff;
   logic              csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_command_ff  <= TYPE_COMMAND_RST;
         type_response_ff <= TYPE_RESPONSE_RST;
         type_alert_ff    <= TYPE_ALERT_RST;
         type_error_ff    <= TYPE_ERROR_RST;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_TYPE_COMMAND:  type_command_ff  <= csr_ch.data;
            CSR_TYPE_RESPONSE: type_response_ff <= csr_ch.data;
            CSR_TYPE_ALERT:    type_alert_ff    <= csr_ch.data;
            CSR_TYPE_ERROR:    type_error_ff    <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   assign type_hit = (rx_byte == type_command_ff) || (rx_byte == type_response_ff) ||
                     (rx_byte == type_alert_ff) || (rx_byte == type_error_ff);

endmodule

[sv/sdep_packet_deframer_top.sv]
// Packet deframer for a stream of received serial bytes.
// The req_ch channel takes one received byte per request. While hunting, a
// byte that matches none of the four type codes is dropped. A matching byte
// is followed by the command id, low byte first, and a length byte.
// The rsp_ch channel gives one header result when the length byte arrives and
// one result for each payload byte; the final result of a packet has last set.
// The csr_ch channel writes the four type codes; it is always ready and should
// only be used while no packet is in progress.
// A result appears on rsp_ch in the cycle after the request that produced it.
// One byte is taken every cycle while rsp_ch is not stalled; the phase register
// and the single result register set that rate.
// Reset returns the deframer to hunting, clears the result valid flag and
// restores the default type codes.
// When the receiver stalls with a result waiting, req_ch.ready drops and no
// further byte is taken until that result has been delivered.
module sdep_packet_deframer_top import sdep_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sdep_req_if.sink   req_ch,
   sdep_rsp_if.source rsp_ch,
   sdep_csr_if.sink   csr_ch
);

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  held_type_ff, held_type_in;
   logic [BYTE_W-1:0]  id_low_ff, id_low_in;
   logic [ID_W-1:0]    held_id_ff, held_id_in;
   logic [COUNT_W-1:0] held_count_ff, held_count_in;
   logic               held_more_ff, held_more_in;
   logic [COUNT_W-1:0] bytes_left_ff, bytes_left_in;
   result_type         result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_accept;
   logic               emit;
   logic               type_hit;
   logic [BYTE_W-1:0]  rx;

   sdep_type_regs u_type_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_ch   (csr_ch),
      .rx_byte  (req_ch.rx_byte),
      .type_hit (type_hit)
   );

   assign rx           = req_ch.rx_byte;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         held_type_ff  <= '0;
         id_low_ff     <= '0;
         held_id_ff    <= '0;
         held_count_ff <= '0;
         held_more_ff  <= 1'b0;
         bytes_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         held_type_ff  <= held_type_in;
         id_low_ff     <= id_low_in;
         held_id_ff    <= held_id_in;
         held_count_ff <= held_count_in;
         held_more_ff  <= held_more_in;
         bytes_left_ff <= bytes_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   always_comb begin
      phase_in      = phase_ff;
      held_type_in  = held_type_ff;
      id_low_in     = id_low_ff;
      held_id_in    = held_id_ff;
      held_count_in = held_count_ff;
      held_more_in  = held_more_ff;
      bytes_left_in = bytes_left_ff;
      emit          = 1'b0;
      result_in     = result_ff;
      if (req_accept) begin
         case (phase_ff)
            PH_ID_LO: begin
               id_low_in = rx;
               phase_in  = PH_ID_HI;
            end
            PH_ID_HI: begin
               held_id_in = {rx, id_low_ff};
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               held_count_in        = rx[COUNT_W-1:0];
               held_more_in         = rx[MORE_BIT];
               bytes_left_in        = rx[COUNT_W-1:0];
               emit                 = 1'b1;
               result_in.item_kind  = KIND_HEADER;
               result_in.data_byte  = '0;
               result_in.last       = (rx[COUNT_W-1:0] == '0);
               phase_in             = result_in.last ? PH_HUNT : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               bytes_left_in        = bytes_left_ff - COUNT_W'(1);
               emit                 = 1'b1;
               result_in.item_kind  = KIND_PAYLOAD;
               result_in.data_byte  = rx;
               result_in.last       = (bytes_left_ff == COUNT_W'(1));
               phase_in             = result_in.last ? PH_HUNT : PH_PAYLOAD;
            end
            default: begin
               if (type_hit) begin
                  held_type_in = rx;
                  phase_in     = PH_ID_LO;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
         if (emit) begin
            result_in.msg_type      = held_type_ff;
            result_in.command_id    = held_id_ff;
            result_in.payload_count = held_count_in;
            result_in.more_data     = held_more_in;
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.item_kind     = result_ff.item_kind;
   assign rsp_ch.msg_type      = result_ff.msg_type;
   assign rsp_ch.command_id    = result_ff.command_id;
   assign rsp_ch.payload_count = result_ff.payload_count;
   assign rsp_ch.more_data     = result_ff.more_data;
   assign rsp_ch.data_byte     = result_ff.data_byte;
   assign rsp_ch.last          = result_ff.last;

   a_len_gives_header: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_LEN |=> rsp_valid_ff && result_ff.item_kind == KIND_HEADER)
      else $error("length byte did not produce a header result");

   a_last_payload_hunts: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_PAYLOAD && bytes_left_ff == COUNT_W'(1)
      |=> phase_ff == PH_HUNT && result_ff.last)
      else $error("final payload byte did not end the packet");

   a_miss_keeps_hunting: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_HUNT && !type_hit |=> phase_ff == PH_HUNT)
      else $error("unmatched byte left the hunting phase");

   a_payload_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> bytes_left_ff != '0)
      else $error("payload phase with no bytes left");

endmodule

[tb/sdep_packet_deframer_top_tb.sv]
`timescale 1ns / 1ps

module sdep_packet_deframer_top_tb;
   import sdep_pkg::*;

   typedef struct {
      csr_idx_type       idx;
      logic [BYTE_W-1:0] code;
   } code_write_type;

   logic clock;
   logic reset;

   sdep_req_if req_ch ();
   sdep_rsp_if rsp_ch ();
   sdep_csr_if csr_ch ();

   sdep_packet_deframer_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [BYTE_W-1:0] byte_queue[$];
   code_write_type    code_write_queue[$];
   result_type        frame_results[$];

   int unsigned bytes_sent;
   int unsigned bytes_taken;
   int unsigned code_writes_sent;
   int unsigned code_writes_done;
   int unsigned mismatch_count;
   int unsigned headers_seen;
   int unsigned payloads_seen;
   int unsigned code_settings;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   logic        long_stall_go;
   logic        long_stall_seen;
   int unsigned stall_left;

   logic [BYTE_W-1:0]  type_code[4];
   phase_type          trk_phase;
   logic [BYTE_W-1:0]  trk_type;
   logic [BYTE_W-1:0]  trk_id_low;
   logic [ID_W-1:0]    trk_id;
   logic [COUNT_W-1:0] trk_left;
   logic [COUNT_W-1:0] trk_count;
   logic               trk_more;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic string fmt_result(input result_type r);
      return $sformatf("kind %0b type %h id %h count %0d more %0b data %h last %0b",
                       r.item_kind, r.msg_type, r.command_id, r.payload_count,
                       r.more_data, r.data_byte, r.last);
   endfunction

   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      result_type r;
      r = '0;
      case (trk_phase)
         PH_ID_LO: begin
            trk_id_low = b;
            trk_phase = PH_ID_HI;
         end
         PH_ID_HI: begin
            trk_id = {b, trk_id_low};
            trk_phase = PH_LEN;
         end
         PH_LEN: begin
            trk_count = b[COUNT_W-1:0];
            trk_more = b[MORE_BIT];
            trk_left = trk_count;
            r.item_kind = KIND_HEADER;
            r.last = (trk_count == '0);
            trk_phase = r.last ? PH_HUNT : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            trk_left = trk_left - 1'b1;
            r.item_kind = KIND_PAYLOAD;
            r.data_byte = b;
            r.last = (trk_left == '0);
            if (r.last) begin
               trk_phase = PH_HUNT;
            end
         end
         default: begin
            if (b == type_code[0] || b == type_code[1] || b == type_code[2] ||
                b == type_code[3]) begin
               trk_type = b;
               trk_phase = PH_ID_LO;
            end else begin
               trk_phase = PH_HUNT;
            end
         end
      endcase
      if (trk_phase == PH_PAYLOAD || r.item_kind == KIND_PAYLOAD || r.last) begin
         r.msg_type = trk_type;
         r.command_id = trk_id;
         r.payload_count = trk_count;
         r.more_data = trk_more;
         if (!(trk_phase == PH_PAYLOAD && r.item_kind == KIND_HEADER && b[COUNT_W-1:0] == '0
               && !r.last)) begin
            frame_results.push_back(r);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.rx_byte <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            deframe_byte(req_ch.rx_byte);
            bytes_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.rx_byte <= byte_queue.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         csr_ch.valid <= 1'b0;
         csr_ch.index <= CSR_TYPE_COMMAND;
         csr_ch.data <= '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            type_code[csr_ch.index] = csr_ch.data;
            code_writes_done++;
         end
         if (!csr_ch.valid || csr_ch.ready) begin
            if (code_write_queue.size() > 0) begin
               csr_ch.valid <= 1'b1;
               csr_ch.index <= code_write_queue[0].idx;
               csr_ch.data <= code_write_queue[0].code;
               void'(code_write_queue.pop_front());
            end else begin
               csr_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (long_stall_go && !long_stall_seen) begin
            long_stall_seen = 1'b1;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.item_kind = rsp_ch.item_kind;
         got.msg_type = rsp_ch.msg_type;
         got.command_id = rsp_ch.command_id;
         got.payload_count = rsp_ch.payload_count;
         got.more_data = rsp_ch.more_data;
         got.data_byte = rsp_ch.data_byte;
         got.last = rsp_ch.last;
         if (got.item_kind === KIND_HEADER) begin
            headers_seen++;
         end else begin
            payloads_seen++;
         end
         if (frame_results.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("Unexpected result at %0t: %s", $realtime, fmt_result(got));
            end
            mismatch_count++;
         end else begin
            want = frame_results.pop_front();
            if (got !== want) begin
               if (mismatch_count < 10) begin
                  $display("Mismatch at %0t: expected %s", $realtime, fmt_result(want));
                  $display("                 got %s", fmt_result(got));
               end
               mismatch_count++;
            end
         end
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      byte_queue.push_back(b);
      bytes_sent++;
   endtask

   task automatic drain();
      wait (bytes_taken == bytes_sent && frame_results.size() == 0);
   endtask

   task automatic close_packet();
      drain();
      while (trk_phase != PH_HUNT) begin
         push_byte(8'h00);
         drain();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_type_codes(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] rsp,
                                 input logic [BYTE_W-1:0] alr, input logic [BYTE_W-1:0] err);
      code_write_queue.push_back('{CSR_TYPE_COMMAND, cmd});
      code_write_queue.push_back('{CSR_TYPE_RESPONSE, rsp});
      code_write_queue.push_back('{CSR_TYPE_ALERT, alr});
      code_write_queue.push_back('{CSR_TYPE_ERROR, err});
      code_writes_sent += 4;
      wait (code_writes_done == code_writes_sent);
      @(posedge clock);
      code_settings++;
   endtask

   task automatic queue_random_packet();
      logic [BYTE_W-1:0] hdr[4];
      int unsigned       count;
      int unsigned       keep;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end
      count = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
      hdr[0] = type_code[$urandom_range(3)];
      hdr[1] = 8'($urandom);
      hdr[2] = 8'($urandom);
      hdr[3] = {1'($urandom), 3'($urandom), 4'(count)};
      keep = ($urandom_range(99) < 8) ? $urandom_range(1, 3) : 4;
      for (int i = 0; i < keep; i++) begin
         push_byte(hdr[i]);
      end
      if (keep == 4) begin
         repeat (count) push_byte(8'($urandom));
      end
   endtask

   task automatic run_random_phase(input int unsigned n_bytes);
      int unsigned start;
      logic        paused;
      start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - start < n_bytes) begin
         queue_random_packet();
         if (!paused && bytes_sent - start >= n_bytes / 2) begin
            paused = 1'b1;
            drain();
         end
      end
      close_packet();
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_TYPE_COMMAND;
      csr_ch.data = '0;
      bytes_sent = 0;
      bytes_taken = 0;
      code_writes_sent = 0;
      code_writes_done = 0;
      mismatch_count = 0;
      headers_seen = 0;
      payloads_seen = 0;
      code_settings = 1;
      send_idle_pct = 0;
      stall_pct = 0;
      long_stall_go = 1'b0;
      long_stall_seen = 1'b0;
      stall_left = 0;
      type_code[0] = TYPE_COMMAND_RST;
      type_code[1] = TYPE_RESPONSE_RST;
      type_code[2] = TYPE_ALERT_RST;
      type_code[3] = TYPE_ERROR_RST;
      trk_phase = PH_HUNT;
      trk_type = '0;
      trk_id_low = '0;
      trk_id = '0;
      trk_left = '0;
      trk_count = '0;
      trk_more = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default type codes: dropped bytes, empty payloads and short payloads.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h10); push_byte(8'h34); push_byte(8'h12); push_byte(8'h00);
      push_byte(8'h20); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hF0);
      push_byte(8'h40); push_byte(8'h00); push_byte(8'h00); push_byte(8'h82);
      push_byte(8'h00); push_byte(8'hFF);
      push_byte(8'h80); push_byte(8'hA5); push_byte(8'h5A); push_byte(8'h01);
      push_byte(8'h80);
      close_packet();

      long_stall_go = 1'b1;
      run_random_phase(300);

      set_type_codes(8'h00, 8'h00, 8'h00, 8'h00);
      send_idle_pct = 72;
      run_random_phase(300);

      set_type_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_idle_pct = 0;
      stall_pct = 72;
      run_random_phase(300);

      set_type_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_idle_pct = 23;
      stall_pct = 23;
      run_random_phase(300);

      set_type_codes(8'h00, 8'hFF, 8'($urandom), TYPE_COMMAND_RST);
      send_idle_pct = 0;
      stall_pct = 0;
      run_random_phase(300);

      drain();
      repeat (20) @(posedge clock);
      $display("Run covered %0d requests under %0d type code settings.", bytes_taken,
               code_settings);
      $display("Checked %0d header and %0d payload results, %0d mismatches.", headers_seen,
               payloads_seen, mismatch_count);
      if (mismatch_count == 0 && frame_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
